@@ hdl/byte_level_pretokenizer_macros.svh @@
// Assertion macros shared by the pretokenizer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BYTE_LEVEL_PRETOKENIZER_MACROS_SVH
`define BYTE_LEVEL_PRETOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// Property holds on every rising clock edge outside reset.
`define BLPT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define BLPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BLPT_ASSERT(lbl, clk, rstn, prop, msg)
`define BLPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hdl/blpt_pkg.sv @@
// Shared types and character constants for the byte-level pretokenizer.
// No dependencies.
package blpt_pkg;

    // Result word, lowest bits first: byte, chunk end, text end.
    typedef struct packed {
        logic       text_last;
        logic       chunk_last;
        logic [7:0] out_byte;
    } t_word;

    typedef enum logic [1:0] {
        CLS_SPACE  = 2'd0,
        CLS_DIGIT  = 2'd1,
        CLS_LETTER = 2'd2,
        CLS_OTHER  = 2'd3
    } t_cls;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_L     = 8'h6C;

endpackage

@@ hdl/blpt_core.sv @@
// Byte hold buffer, chunk boundary decision and end-of-text flush sequencer.
// Depends on blpt_pkg and the assertion macro header.
`include "byte_level_pretokenizer_macros.svh"

module blpt_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_eot,
    output logic           o_valid,
    input  logic           i_ready,
    output blpt_pkg::t_word o_word
);
    import blpt_pkg::*;

    typedef struct packed {
        logic [1:0] cp;     // bytes of an open contraction still to come
        logic       start;  // next emitted byte starts a chunk
        logic       sp;     // joining space just emitted
        t_cls       cls;    // class of the open run
    } t_ctx;

    localparam t_ctx CTX_RST = '{cp: 2'd0, start: 1'b1, sp: 1'b0, cls: CLS_SPACE};

    function automatic t_cls classify(input logic [7:0] c);
        t_cls res;
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})
            res = CLS_SPACE;
        else if (c inside {[CH_0:CH_9]})
            res = CLS_DIGIT;
        else if (c inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]} || c[7])
            res = CLS_LETTER;
        else
            res = CLS_OTHER;
        return res;
    endfunction

    logic [7:0] r_buf [3];
    logic [7:0] n_buf [3];
    logic [1:0] r_cnt, n_cnt;
    logic       r_flush, n_flush;
    t_ctx       r_ctx, n_ctx;

    logic       s_fire;
    logic       emit;
    logic       has1, has2;
    logic [7:0] b0, b1, b2;
    logic       con2, con3;
    logic       go;
    logic       dec_last;
    t_cls       run_cls;
    t_ctx       dec_ctx;

    assign o_ready = !r_flush && ((r_cnt < 2'd2) || i_ready);
    assign s_fire  = i_valid && o_ready;

    // Lookahead: the live input while streaming, the buffer tail while flushing
    assign b0   = r_buf[0];
    assign b1   = r_buf[1];
    assign b2   = r_flush ? r_buf[2] : i_byte;
    assign has1 = r_flush ? (r_cnt >= 2'd2) : 1'b1;
    assign has2 = r_flush ? (r_cnt == 2'd3) : 1'b1;

    assign con2 = (b0 == CH_APOS) && has1 &&
                  (b1 == CH_S || b1 == CH_T || b1 == CH_M || b1 == CH_D);
    assign con3 = (b0 == CH_APOS) && has2 &&
                  ((b1 == CH_R && b2 == CH_E) || (b1 == CH_V && b2 == CH_E) ||
                   (b1 == CH_L && b2 == CH_L));

    always_comb begin
        dec_ctx  = r_ctx;
        dec_last = 1'b0;
        run_cls  = r_ctx.cls;
        go       = 1'b1;
        if (r_ctx.cp != 2'd0) begin
            dec_ctx.cp = r_ctx.cp - 2'd1;
            dec_last   = (r_ctx.cp == 2'd1);
            if (dec_last)
                dec_ctx.start = 1'b1;
        end else begin
            if (r_ctx.start) begin
                dec_ctx.start = 1'b0;
                if (con2) begin
                    dec_ctx.cp = 2'd1;
                    go         = 1'b0;
                end else if (con3) begin
                    dec_ctx.cp = 2'd2;
                    go         = 1'b0;
                end else if (b0 == CH_SPACE && has1 && b1 != CH_SPACE) begin
                    dec_ctx.sp = 1'b1;
                    go         = 1'b0;
                end else begin
                    run_cls = classify(b0);
                end
            end else if (r_ctx.sp) begin
                dec_ctx.sp = 1'b0;
                run_cls    = classify(b0);
            end
            if (go) begin
                dec_ctx.cls = run_cls;
                dec_last    = !has1 || (classify(b1) != run_cls);
                if (dec_last)
                    dec_ctx.start = 1'b1;
            end
        end
    end

    assign emit = r_flush ? i_ready : (s_fire && !i_eot && (r_cnt == 2'd2));

    always_comb begin
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_flush = r_flush;
        n_ctx   = r_ctx;
        if (r_flush) begin
            if (i_ready) begin
                n_buf[0] = r_buf[1];
                n_buf[1] = r_buf[2];
                n_cnt    = r_cnt - 2'd1;
                n_ctx    = dec_ctx;
                if (r_cnt == 2'd1) begin
                    n_flush = 1'b0;
                    n_ctx   = CTX_RST;
                end
            end
        end else if (s_fire) begin
            if (i_eot) begin
                case (r_cnt)
                    2'd0:    n_buf[0] = i_byte;
                    2'd1:    n_buf[1] = i_byte;
                    default: n_buf[2] = i_byte;
                endcase
                n_cnt   = r_cnt + 2'd1;
                n_flush = 1'b1;
            end else if (r_cnt == 2'd2) begin
                n_buf[0] = r_buf[1];
                n_buf[1] = i_byte;
                n_ctx    = dec_ctx;
            end else begin
                case (r_cnt)
                    2'd0:    n_buf[0] = i_byte;
                    default: n_buf[1] = i_byte;
                endcase
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_flush <= 1'b0;
            r_ctx   <= CTX_RST;
        end else begin
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
            r_ctx   <= n_ctx;
        end
    end

    assign o_valid           = emit;
    assign o_word.out_byte   = r_buf[0];
    assign o_word.chunk_last = dec_last;
    assign o_word.text_last  = r_flush && (r_cnt == 2'd1);

    `BLPT_ASSERT(a_cnt_range, i_clk, i_rst_n, r_flush || (r_cnt != 2'd3),
                 "three bytes held outside a flush")
    `BLPT_ASSERT(a_flush_nonempty, i_clk, i_rst_n, !r_flush || (r_cnt != 2'd0),
                 "flush with an empty buffer")
    `BLPT_ASSERT(a_ctx_excl, i_clk, i_rst_n, !((r_ctx.cp != 2'd0) && r_ctx.sp),
                 "contraction open while a joining space is pending")
    `BLPT_ASSERT_NEXT(a_flush_end, i_clk, i_rst_n, r_flush && i_ready && (r_cnt == 2'd1),
                      !r_flush && (r_cnt == 2'd0) && r_ctx.start,
                      "state not returned to start after the final word")

endmodule

@@ hdl/blpt_skid.sv @@
// Two-entry output register with skid slot; upstream ready is a flop.
// Depends on blpt_pkg and the assertion macro header.
`include "byte_level_pretokenizer_macros.svh"

module blpt_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  blpt_pkg::t_word i_word,
    output logic            o_valid,
    input  logic            i_ready,
    output blpt_pkg::t_word o_word
);
    import blpt_pkg::*;

    logic  r_main_valid, r_skid_valid;
    t_word r_main, r_skid;
    logic  main_load;

    assign o_ready   = !r_skid_valid;
    assign main_load = !r_main_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (main_load) begin
            r_main <= r_skid_valid ? r_skid : i_word;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_word;
        end
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_load) begin
            r_main_valid <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid = r_main_valid;
    assign o_word  = r_main;

    `BLPT_ASSERT(a_skid_implies_main, i_clk, i_rst_n, !r_skid_valid || r_main_valid,
                 "skid slot full with output register empty")
    `BLPT_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n,
                      i_valid && !r_skid_valid && r_main_valid && !i_ready,
                      r_skid_valid, "stalled word not caught in skid slot")
    `BLPT_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && i_ready,
                      !r_skid_valid, "skid slot not drained on output accept")

endmodule

@@ hdl/byte_level_pretokenizer.sv @@
// Byte-level pretokenizer: top level joining the chunking core and output stage.
// Depends on blpt_pkg, blpt_core and blpt_skid.
//
// Usage: text enters on the slave stream one byte per word, with tlast on the
// final byte of a text. The master stream returns every byte unchanged and in
// order; tuser marks the last byte of a pretoken chunk (contraction, or a run
// of one class with an optional single leading space) and tlast marks the
// final byte of the text.
// Throughput: one byte per cycle while streaming and the skid slot is empty. A
// byte leaves once two more bytes of the same text have arrived (its lookahead),
// then passes through the output register. On tlast the held bytes plus the
// final byte (one to three words) are flushed one per cycle while the skid slot
// is empty; input is not taken during the flush.
// Reset (synchronous, active low) drops held bytes and starts a new text.
// When the receiver stalls, the output register and a one-word skid slot
// absorb results; input stalls once the skid slot fills. Ready comes from flops.
module byte_level_pretokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // end_of_text
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // chunk_last
    output logic       o_m_tlast    // text_last
);
    import blpt_pkg::*;

    logic  core_valid, skid_ready;
    t_word core_word, out_word;

    blpt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_eot   (i_s_tlast),
        .o_valid (core_valid),
        .i_ready (skid_ready),
        .o_word  (core_word)
    );

    blpt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .o_ready (skid_ready),
        .i_word  (core_word),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_word  (out_word)
    );

    assign o_m_tdata = out_word.out_byte;
    assign o_m_tuser = out_word.chunk_last;
    assign o_m_tlast = out_word.text_last;

endmodule
